>>> design/npt_pkg.sv
// npt_pkg: shared types, widths and codes of the nearest point table.
// Used by nearest_point_table_unit and its checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package npt_pkg;

  // Field widths
  localparam int unsigned CoordW   = 16;
  localparam int unsigned LimitW   = 17;
  localparam int unsigned SqW      = 2 * CoordW;        // one squared axis delta
  localparam int unsigned SumW     = 2 * LimitW;        // sum of squares, also limit^2
  localparam int unsigned RootW    = 25;                // floor(256*sqrt(sum))
  localparam int unsigned RadW     = 2 * RootW;         // sum << 16
  localparam int unsigned RemW     = RootW + 2;
  localparam int unsigned StepW    = $clog2(RootW + 1);
  localparam int unsigned ThreshW  = 2 * (RootW + 1);   // (root + 1)^2
  localparam int unsigned DistW    = 26;
  localparam int unsigned IndexW   = 7;
  localparam int unsigned CountW   = 8;
  localparam int unsigned FracBits = 8;

  localparam int unsigned DefaultCapacity = 128;
  localparam logic [LimitW-1:0] LimitReset = 17'd100000;

  // Command codes
  localparam logic [1:0] CMD_PUSH    = 2'd0;
  localparam logic [1:0] CMD_POP     = 2'd1;
  localparam logic [1:0] CMD_NEAREST = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic               [1:0]        cmd;
    logic signed        [CoordW-1:0] coord_x;
    logic signed        [CoordW-1:0] coord_y;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              found;
    logic [IndexW-1:0] nearest_index;
    logic [DistW-1:0]  nearest_distance;
    logic [CountW-1:0] point_count;
  } rsp_t;

endpackage

`default_nettype wire

>>> design/nearest_point_table_unit.sv
// nearest_point_table_unit: stack of 2-D points with a nearest-point search.
// Depends on npt_pkg. Checker in npt_checker.sv binds to this module.
// Flow to out_valid_o: push, pop and unused codes pass through ST_EMIT after the request is
//   taken. A search with a hit runs two scans of the N stored points (one read per cycle
//   plus the square pipeline), a 25-step bit-serial square root, ST_THRESH for the bound
//   and ST_EMIT. No hit: one scan, which issues no reads with nothing stored.
// Requests: one in work at a time; the next is taken once the response loads, later if
//   the output is stalled.
// Reset (rst_ni low, async): stack empty, distance limit 100000, no response pending.
`timescale 1ns / 1ps
`default_nettype none

module nearest_point_table_unit #(
  parameter int unsigned CAPACITY = npt_pkg::DefaultCapacity
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [npt_pkg::LimitW-1:0]     cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output      logic                           in_ready_o,
  input  wire npt_pkg::req_t                  in_req_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_ready_i,
  output      npt_pkg::rsp_t                  out_rsp_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Search flow:
  //   SCAN pass 0: find the smallest sum of squares below limit^2 (sqrt is
  //     monotonic, so squares stand in for distances).
  //   ROOT: floor(sqrt(best << 16)), one result bit per cycle.
  //   THRESH: (root + 1)^2 bounds every sum that floors to the same distance.
  //   SCAN pass 1: the first point under that bound is the one reported,
  //     since several sums can floor to one distance.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ROOT,
    ST_THRESH,
    ST_EMIT
  } state_e;

  state_e                          state_q;
  logic [CW-1:0]                   cnt_q;
  logic [npt_pkg::LimitW-1:0]      limit_q;
  logic signed [npt_pkg::CoordW-1:0] qx_q, qy_q;
  logic                            pass_q;

  // Scan pipeline: read address, memory data, squared deltas
  logic [CW-1:0]                   rd_idx_q;
  logic                            v1_q, v2_q;
  logic [CW-1:0]                   i1_q, i2_q;
  logic [npt_pkg::SqW-1:0]         rdata_q;
  logic [npt_pkg::SqW-1:0]         sq_x_q, sq_y_q;

  // Search results
  logic [npt_pkg::SumW-1:0]        best_s_q;
  logic                            found_q, hit_q;
  logic [CW-1:0]                   idx_q;

  // Square root
  logic [npt_pkg::RadW-1:0]        rad_q;
  logic [npt_pkg::RemW-1:0]        rem_q;
  logic [npt_pkg::RootW-1:0]       root_q;
  logic [npt_pkg::StepW-1:0]       step_q;
  logic [npt_pkg::ThreshW-1:0]     thresh_q;

  npt_pkg::rsp_t                   res_q, out_q;
  logic                            out_valid_q;

  logic [npt_pkg::SqW-1:0]         mem [CAPACITY];

  // ---------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------
  logic in_fire, full, empty, mem_we, rd_en, scan_done;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  assign full   = (cnt_q >= CW'(CAPACITY));
  assign empty  = (cnt_q == '0);
  assign mem_we = in_fire && (in_req_i.cmd == npt_pkg::CMD_PUSH) && !full;

  // one read per cycle until every stored point is issued
  assign rd_en     = (state_q == ST_SCAN) && (rd_idx_q != cnt_q);
  assign scan_done = (state_q == ST_SCAN) && !rd_en && !v1_q && !v2_q;

  // ---------------------------------------------------------------
  // Point memory: one write port (push), one registered read port (scan)
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cnt_q[AW-1:0]] <= {in_req_i.coord_y, in_req_i.coord_x};
    end
    if (rd_en) begin
      rdata_q <= mem[rd_idx_q[AW-1:0]];
    end
  end

  // ---------------------------------------------------------------
  // Datapath helpers
  // ---------------------------------------------------------------
  logic signed [npt_pkg::CoordW:0]   dx, dy;
  logic [npt_pkg::CoordW-1:0]        ax, ay;
  logic [npt_pkg::SumW-1:0]          s_sum;
  logic [npt_pkg::ThreshW-1:0]       s_shift;
  logic [npt_pkg::RemW-1:0]          rem_sh, trial;
  logic [npt_pkg::RootW:0]           root_inc;
  logic                              push_ok, pop_ok;
  npt_pkg::rsp_t                     acc_rsp;

  always_comb begin
    dx = {qx_q[npt_pkg::CoordW-1], qx_q}
       - {rdata_q[npt_pkg::CoordW-1], rdata_q[npt_pkg::CoordW-1:0]};
    dy = {qy_q[npt_pkg::CoordW-1], qy_q}
       - {rdata_q[npt_pkg::SqW-1], rdata_q[npt_pkg::SqW-1:npt_pkg::CoordW]};
    ax = dx[npt_pkg::CoordW] ? npt_pkg::CoordW'(-dx) : dx[npt_pkg::CoordW-1:0];
    ay = dy[npt_pkg::CoordW] ? npt_pkg::CoordW'(-dy) : dy[npt_pkg::CoordW-1:0];

    s_sum   = npt_pkg::SumW'(sq_x_q) + npt_pkg::SumW'(sq_y_q);
    s_shift = npt_pkg::ThreshW'({s_sum, 16'b0});

    rem_sh   = {rem_q[npt_pkg::RootW-1:0], rad_q[npt_pkg::RadW-1 -: 2]};
    trial    = {root_q, 2'b01};
    root_inc = {1'b0, root_q} + 1'b1;

    push_ok = !full;
    pop_ok  = !empty;

    // response fields known when the request is taken
    acc_rsp             = '0;
    acc_rsp.point_count = npt_pkg::CountW'(cnt_q);
    unique case (in_req_i.cmd)
      npt_pkg::CMD_PUSH: begin
        if (push_ok) begin
          acc_rsp.point_count = npt_pkg::CountW'(cnt_q + 1'b1);
        end else begin
          acc_rsp.status = npt_pkg::STAT_FULL;
        end
      end
      npt_pkg::CMD_POP: begin
        if (pop_ok) begin
          acc_rsp.point_count = npt_pkg::CountW'(cnt_q - 1'b1);
        end else begin
          acc_rsp.status = npt_pkg::STAT_EMPTY;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------
  // Control and registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      limit_q     <= npt_pkg::LimitReset;
      qx_q        <= '0;
      qy_q        <= '0;
      pass_q      <= 1'b0;
      rd_idx_q    <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      i1_q        <= '0;
      i2_q        <= '0;
      sq_x_q      <= '0;
      sq_y_q      <= '0;
      best_s_q    <= '0;
      found_q     <= 1'b0;
      hit_q       <= 1'b0;
      idx_q       <= '0;
      rad_q       <= '0;
      rem_q       <= '0;
      root_q      <= '0;
      step_q      <= '0;
      thresh_q    <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end

      // ST_EMIT reloads the output register itself
      if (out_valid_q && out_ready_i && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end

      // scan pipeline, runs freely; valid bits drain outside ST_SCAN
      v1_q   <= rd_en;
      i1_q   <= rd_idx_q;
      v2_q   <= v1_q;
      i2_q   <= i1_q;
      sq_x_q <= ax * ax;
      sq_y_q <= ay * ay;
      if (rd_en) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            res_q <= acc_rsp;
            unique case (in_req_i.cmd)
              npt_pkg::CMD_PUSH: begin
                if (push_ok) begin
                  cnt_q <= cnt_q + 1'b1;
                end
                state_q <= ST_EMIT;
              end
              npt_pkg::CMD_POP: begin
                if (pop_ok) begin
                  cnt_q <= cnt_q - 1'b1;
                end
                state_q <= ST_EMIT;
              end
              npt_pkg::CMD_NEAREST: begin
                qx_q     <= in_req_i.coord_x;
                qy_q     <= in_req_i.coord_y;
                best_s_q <= limit_q * limit_q;  // strict below limit^2 qualifies
                found_q  <= 1'b0;
                pass_q   <= 1'b0;
                rd_idx_q <= '0;
                state_q  <= ST_SCAN;
              end
              default: begin
                state_q <= ST_EMIT;
              end
            endcase
          end
        end

        ST_SCAN: begin
          if (v2_q) begin
            if (!pass_q) begin
              if (s_sum < best_s_q) begin
                best_s_q <= s_sum;
                found_q  <= 1'b1;
              end
            end else if (!hit_q && (s_shift < thresh_q)) begin
              hit_q <= 1'b1;
              idx_q <= i2_q;
            end
          end
          if (scan_done) begin
            if (pass_q) begin
              res_q.found            <= 1'b1;
              res_q.nearest_index    <= npt_pkg::IndexW'(idx_q);
              res_q.nearest_distance <= npt_pkg::DistW'(root_q);
              state_q <= ST_EMIT;
            end else if (found_q) begin
              rad_q   <= {best_s_q, 16'b0};
              rem_q   <= '0;
              root_q  <= '0;
              step_q  <= '0;
              state_q <= ST_ROOT;
            end else begin
              // nothing below the limit: report the limit itself
              res_q.nearest_distance <=
                npt_pkg::DistW'({limit_q, {npt_pkg::FracBits{1'b0}}});
              state_q <= ST_EMIT;
            end
          end
        end

        ST_ROOT: begin
          // restoring square root, two radicand bits per step
          if (rem_sh >= trial) begin
            rem_q  <= rem_sh - trial;
            root_q <= {root_q[npt_pkg::RootW-2:0], 1'b1};
          end else begin
            rem_q  <= rem_sh;
            root_q <= {root_q[npt_pkg::RootW-2:0], 1'b0};
          end
          rad_q  <= {rad_q[npt_pkg::RadW-3:0], 2'b00};
          step_q <= step_q + 1'b1;
          if (step_q == npt_pkg::StepW'(npt_pkg::RootW - 1)) begin
            state_q <= ST_THRESH;
          end
        end

        ST_THRESH: begin
          thresh_q <= root_inc * root_inc;
          pass_q   <= 1'b1;
          hit_q    <= 1'b0;
          rd_idx_q <= '0;
          state_q  <= ST_SCAN;
        end

        ST_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/npt_checker.sv
// npt_checker: port-level checks of nearest_point_table_unit, bound below.
// Depends on npt_pkg and on nearest_point_table_unit.
`timescale 1ns / 1ps
`default_nettype none

module npt_checker #(
  parameter int unsigned CAPACITY = npt_pkg::DefaultCapacity
) (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire npt_pkg::rsp_t out_rsp_o
);

  // a stalled response holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("response changed while stalled");

  // a found point is only reported on a clean search
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.found |-> out_rsp_o.status == npt_pkg::STAT_OK)
    else $error("found set on refused request");

  // refused requests carry no search result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status == npt_pkg::STAT_FULL ||
                    out_rsp_o.status == npt_pkg::STAT_EMPTY)
    |-> out_rsp_o.nearest_distance == '0 && out_rsp_o.nearest_index == '0)
    else $error("search fields set on refused request");

  // full and empty refusals agree with the reported count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == npt_pkg::STAT_FULL
    |-> out_rsp_o.point_count == npt_pkg::CountW'(CAPACITY))
    else $error("full refusal with wrong count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == npt_pkg::STAT_EMPTY
    |-> out_rsp_o.point_count == '0)
    else $error("empty refusal with nonzero count");

endmodule

bind nearest_point_table_unit npt_checker #(
  .CAPACITY(CAPACITY)
) u_npt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_rsp_o  (out_rsp_o)
);

`default_nettype wire
